[rtl/gfa_pkg.sv]
// Shared constants, types and field helpers for the Goldilocks field ALU.
package gfa_pkg;

	localparam logic [63:0] GL_P      = 64'hFFFF_FFFF_0000_0001;
	localparam logic [63:0] GL_EPS    = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] GL_P_M2   = GL_P - 64'd2;

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_MUL = 3'd2;
	localparam logic [2:0] FN_POW = 3'd3;
	localparam logic [2:0] FN_INV = 3'd4;
	localparam logic [2:0] FN_RED = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CANON,
		ST_DISP,
		ST_PSTEP,
		ST_MP0,
		ST_MP1,
		ST_MP2,
		ST_MP3,
		ST_MCOMB,
		ST_MRED,
		ST_MADD,
		ST_MSUB,
		ST_OUT
	} gfa_state_t;

	function automatic logic [63:0] fld_canon(input logic [63:0] x);
		fld_canon = (x >= GL_P) ? (x - GL_P) : x;
	endfunction

	function automatic logic [63:0] fld_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[64]) begin
			fld_add = s[63:0] + GL_EPS;
		end else if (s[63:0] >= GL_P) begin
			fld_add = s[63:0] - GL_P;
		end else begin
			fld_add = s[63:0];
		end
	endfunction

	function automatic logic [63:0] fld_sub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a - b;
		fld_sub = (a < b) ? (r + GL_P) : r;
	endfunction

endpackage

[rtl/goldilocks_field_alu.sv]
// Top level of the Goldilocks field ALU: sequencer around one shared 32x32 multiplier.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, func, operand_a/b | sink
//  out     | out_valid, out_stall, result          | source
//
// Add, subtract, reduce and unused codes: the result is shown after the canon and dispatch states.
// Each modular product runs four partial products through the one 32x32 multiplier,
// then four fold steps. Power and inverse: one product per set exponent bit plus one
// squaring per bit below the top set bit, up to 127 products.
// Reset clears the sequencer only. in_stall is high in every state but idle, so from after
// the input beat until the result beat is taken; a stalled result holds in its register.
module goldilocks_field_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result
);
	import gfa_pkg::*;

	gfa_state_t state_q, state_d;

	logic [2:0]  func_q;
	logic [63:0] a_q, b_q, exp_q, acc_q, res_q;
	logic [63:0] mx_q, my_q;
	logic        sq_q;
	logic [63:0] p00_q, p01_q, p10_q, p11_q;
	logic [63:0] lo_q, hi_q, t_q, sum_q;

	logic [31:0] mul_x, mul_y;
	logic [63:0] mul_p;
	logic [33:0] mid;
	logic [63:0] mul_r;
	logic [63:0] simple_r;

	// Operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_MP0:  begin mul_x = mx_q[31:0];  mul_y = my_q[31:0];  end
			ST_MP1:  begin mul_x = mx_q[31:0];  mul_y = my_q[63:32]; end
			ST_MP2:  begin mul_x = mx_q[63:32]; mul_y = my_q[31:0];  end
			default: begin mul_x = mx_q[63:32]; mul_y = my_q[63:32]; end
		endcase
	end

	assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};
	assign mid   = {2'd0, p00_q[63:32]} + {2'd0, p01_q[31:0]} + {2'd0, p10_q[31:0]};
	assign mul_r = fld_sub(sum_q, {32'd0, hi_q[63:32]});

	always_comb begin
		case (func_q)
			FN_ADD:  simple_r = fld_add(a_q, b_q);
			FN_SUB:  simple_r = fld_sub(a_q, b_q);
			FN_RED:  simple_r = a_q;
			default: simple_r = 64'd0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CANON;
			ST_CANON: state_d = ST_DISP;
			ST_DISP: begin
				if (func_q == FN_MUL) begin
					state_d = ST_MP0;
				end else if (func_q == FN_POW || func_q == FN_INV) begin
					state_d = ST_PSTEP;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_PSTEP: state_d = (exp_q == 64'd0) ? ST_OUT : ST_MP0;
			ST_MP0:   state_d = ST_MP1;
			ST_MP1:   state_d = ST_MP2;
			ST_MP2:   state_d = ST_MP3;
			ST_MP3:   state_d = ST_MCOMB;
			ST_MCOMB: state_d = ST_MRED;
			ST_MRED:  state_d = ST_MADD;
			ST_MADD:  state_d = ST_MSUB;
			ST_MSUB: begin
				if (func_q == FN_MUL) begin
					state_d = ST_OUT;
				end else if (sq_q || exp_q[63:1] == 63'd0) begin
					state_d = ST_PSTEP;
				end else begin
					state_d = ST_MP0;
				end
			end
			ST_OUT:   if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					func_q <= func;
					a_q    <= operand_a;
					b_q    <= operand_b;
					exp_q  <= operand_b;
				end
			end
			ST_CANON: begin
				a_q   <= fld_canon(a_q);
				b_q   <= fld_canon(b_q);
				acc_q <= 64'd1;
				if (func_q == FN_INV) exp_q <= GL_P_M2;
			end
			ST_DISP: begin
				res_q <= simple_r;
				mx_q  <= a_q;
				my_q  <= b_q;
				sq_q  <= 1'b0;
			end
			ST_PSTEP: begin
				res_q <= acc_q;
				// multiply into the accumulator for a set bit, else square the base
				mx_q  <= exp_q[0] ? acc_q : a_q;
				my_q  <= a_q;
				sq_q  <= !exp_q[0];
			end
			ST_MP0: p00_q <= mul_p;
			ST_MP1: p01_q <= mul_p;
			ST_MP2: p10_q <= mul_p;
			ST_MP3: p11_q <= mul_p;
			ST_MCOMB: begin
				lo_q <= {mid[31:0], p00_q[31:0]};
				hi_q <= p11_q + {32'd0, p01_q[63:32]} + {32'd0, p10_q[63:32]}
					+ {62'd0, mid[33:32]};
			end
			ST_MRED: begin
				// hi_lo * (2^32 - 1), below p
				t_q  <= {hi_q[31:0], 32'd0} - {32'd0, hi_q[31:0]};
				lo_q <= fld_canon(lo_q);
			end
			ST_MADD: sum_q <= fld_add(lo_q, t_q);
			ST_MSUB: begin
				res_q <= mul_r;
				if (sq_q) begin
					a_q   <= mul_r;
					exp_q <= {1'b0, exp_q[63:1]};
				end else begin
					acc_q <= mul_r;
					if (exp_q[63:1] == 63'd0) begin
						exp_q <= 64'd0;
					end else begin
						// square the base next
						mx_q <= a_q;
						my_q <= a_q;
						sq_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
